### hw/rtl/pid_controller_downsampled_integral_assert.svh
// Assertion macros for the PID controller RTL.
// Included by the top level; depends on nothing else.
`ifndef PID_CONTROLLER_DOWNSAMPLED_INTEGRAL_ASSERT_SVH
`define PID_CONTROLLER_DOWNSAMPLED_INTEGRAL_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PIDDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pidds: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PIDDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pidds: next-cycle check failed");

`endif

### hw/rtl/pidds_pkg.sv
// Shared constants, types and helper functions of the PID controller.
// No dependencies; used by pidds_div and the top level.
package pidds_pkg;

    localparam int DATA_W      = 16;   // err_sample, err_slope, gains, drive
    localparam int LIM_W       = 15;   // clamp registers
    localparam int SPAN_W      = 13;   // average_span, sample count
    localparam int SUM_W       = 29;   // error accumulator
    localparam int INTEG_W     = 32;   // integral state
    localparam int PROD_W      = 2 * DATA_W;
    localparam int SCALE_SHIFT = 8;
    localparam int SCALE_ONE   = 1 << SCALE_SHIFT;
    localparam int MAX_SPAN    = 4096;
    localparam int SPAN_RESET  = 256;  // average_span after reset
    localparam int ILIM_W      = LIM_W + SCALE_SHIFT;
    localparam int CLAMP_W     = 34;
    localparam int DIV_STEPS   = SUM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int REM_W       = SPAN_W + 1;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_PROP_CLAMP  = 3'd3,
        REG_INTEG_CLAMP = 3'd4,
        REG_DERIV_CLAMP = 3'd5,
        REG_DRIVE_CLAMP = 3'd6,
        REG_AVG_SPAN    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic                     start;
        logic signed [SUM_W-1:0]  dividend;
        logic [SPAN_W-1:0]        divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quotient;
    } div_rsp_t;

    // Divide by SCALE_ONE, truncating toward zero.
    function automatic logic signed [PROD_W-1:0] div_scale(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] biased;
        biased = v[PROD_W-1] ? (v + PROD_W'(SCALE_ONE - 1)) : v;
        return biased >>> SCALE_SHIFT;
    endfunction

    // Symmetric clamp to +/- lim.
    function automatic logic signed [CLAMP_W-1:0] clamp_sym(
        input logic signed [CLAMP_W-1:0] v,
        input logic [ILIM_W-1:0]         lim
    );
        logic signed [CLAMP_W-1:0] l;
        l = $signed({{(CLAMP_W - ILIM_W){1'b0}}, lim});
        if (v > l) begin
            return l;
        end
        if (v < -l) begin
            return -l;
        end
        return v;
    endfunction

endpackage

### hw/rtl/pid_controller_downsampled_integral.sv
// Top level of the fixed-point PID controller with a downsampled integral.
// Depends on pidds_pkg, pidds_div and pid_controller_downsampled_integral_assert.svh.
//
//   port group  dir  beat contents
//   s_*         in   tuser: opcode; tdata: err_sample, err_slope
//   m_*         out  tdata: drive
//   cfg_*       in   register writes, index per register list, no read-back
//
// Sequence: a step runs MUL_P, MUL_D, SUM, TOTAL, DONE; one that closes an
// averaging window adds DIV (29-step divider for the mean), MUL_I and INTEG.
// A clear goes straight to DONE. One shared 16x16 multiplier forms P, D and the
// integral increment in turn. s_tready is high only while the sequencer idles;
// a finished result waits in the output register while the next beat is taken.
// Reset (aresetn, synchronous) zeroes integral, sum and count and loads defaults.
`include "pid_controller_downsampled_integral_assert.svh"

module pid_controller_downsampled_integral
    import pidds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // [15:0] err_sample, [31:16] err_slope
    input  logic [0:0]          s_tuser,   // [0] opcode

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,   // [15:0] drive

    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [DATA_W-1:0]   cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_D,
        ST_SUM,
        ST_DIV,
        ST_MUL_I,
        ST_INTEG,
        ST_TOTAL,
        ST_DONE
    } state_t;

    // Configuration registers
    logic signed [DATA_W-1:0] prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [LIM_W-1:0]         prop_clamp_reg, integ_clamp_reg;
    logic [LIM_W-1:0]         deriv_clamp_reg, drive_clamp_reg;
    logic [SPAN_W-1:0]        average_span_reg;

    // Sequencer and datapath registers
    state_t                    state_reg, state_next;
    logic signed [DATA_W-1:0]  err_reg, err_next;
    logic signed [DATA_W-1:0]  slope_reg, slope_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [DATA_W-1:0]  p_reg, p_next;
    logic signed [DATA_W-1:0]  d_reg, d_next;
    logic signed [DATA_W-1:0]  mean_reg, mean_next;
    logic signed [INTEG_W-1:0] integral_reg, integral_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [SPAN_W-1:0]         count_reg, count_next;
    logic signed [DATA_W-1:0]  res_reg, res_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]         m_tdata_reg, m_tdata_next;

    logic                      s_acc;
    logic signed [DATA_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0]  term_scaled;
    logic signed [CLAMP_W-1:0] p_clamped, d_clamped;
    logic [SPAN_W-1:0]         span_eff;
    logic [SPAN_W-1:0]         count_inc;
    logic signed [SUM_W-1:0]   sum_inc;
    logic signed [CLAMP_W-1:0] integ_sum, integ_clamped;
    logic signed [CLAMP_W-1:0] total, total_clamped;
    logic signed [PROD_W-1:0]  integ_out;
    logic                      div_start;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;
    logic                      clear_beat;
    logic                      integ_empty;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg    <= '0;
            integ_gain_reg   <= '0;
            deriv_gain_reg   <= '0;
            prop_clamp_reg   <= '0;
            integ_clamp_reg  <= '0;
            deriv_clamp_reg  <= '0;
            drive_clamp_reg  <= '0;
            average_span_reg <= SPAN_W'(SPAN_RESET);
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_PROP_GAIN:   prop_gain_reg    <= $signed(cfg_wdata);
                REG_INTEG_GAIN:  integ_gain_reg   <= $signed(cfg_wdata);
                REG_DERIV_GAIN:  deriv_gain_reg   <= $signed(cfg_wdata);
                REG_PROP_CLAMP:  prop_clamp_reg   <= cfg_wdata[LIM_W-1:0];
                REG_INTEG_CLAMP: integ_clamp_reg  <= cfg_wdata[LIM_W-1:0];
                REG_DERIV_CLAMP: deriv_clamp_reg  <= cfg_wdata[LIM_W-1:0];
                REG_DRIVE_CLAMP: drive_clamp_reg  <= cfg_wdata[LIM_W-1:0];
                REG_AVG_SPAN:    average_span_reg <= cfg_wdata[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Shared multiplier: operands follow the sequencer step, product registered
    always_comb begin
        case (state_reg)
            ST_MUL_P: begin
                mul_a = err_reg;
                mul_b = prop_gain_reg;
            end
            ST_MUL_D: begin
                mul_a = slope_reg;
                mul_b = deriv_gain_reg;
            end
            default: begin
                mul_a = mean_reg;
                mul_b = integ_gain_reg;
            end
        endcase
    end
    assign prod_next = mul_a * mul_b;

    // P and D share the scale-and-clamp path; prod_reg holds whichever is due
    assign term_scaled = div_scale(prod_reg);
    assign p_clamped   = clamp_sym(CLAMP_W'(term_scaled),
                                   {{SCALE_SHIFT{1'b0}}, prop_clamp_reg});
    assign d_clamped   = clamp_sym(CLAMP_W'(term_scaled),
                                   {{SCALE_SHIFT{1'b0}}, deriv_clamp_reg});

    // Span of zero acts as one; spans above the maximum saturate
    always_comb begin
        if (average_span_reg == '0) begin
            span_eff = SPAN_W'(1);
        end else if (average_span_reg > SPAN_W'(MAX_SPAN)) begin
            span_eff = SPAN_W'(MAX_SPAN);
        end else begin
            span_eff = average_span_reg;
        end
    end

    assign count_inc = count_reg + 1'b1;
    assign sum_inc   = sum_reg + SUM_W'(err_reg);

    assign integ_sum     = CLAMP_W'(integral_reg) + CLAMP_W'(prod_reg);
    assign integ_clamped = clamp_sym(integ_sum, {integ_clamp_reg, {SCALE_SHIFT{1'b0}}});

    assign integ_out     = div_scale(integral_reg);
    assign total         = CLAMP_W'(p_reg) + CLAMP_W'(d_reg) + CLAMP_W'(integ_out);
    assign total_clamped = clamp_sym(total, {{SCALE_SHIFT{1'b0}}, drive_clamp_reg});

    assign div_req.start    = div_start;
    assign div_req.dividend = sum_inc;
    assign div_req.divisor  = count_inc;

    pidds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        err_next      = err_reg;
        slope_next    = slope_reg;
        p_next        = p_reg;
        d_next        = d_reg;
        mean_next     = mean_reg;
        integral_next = integral_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        div_start     = 1'b0;

        // drop the output beat once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    err_next   = $signed(s_tdata[DATA_W-1:0]);
                    slope_next = $signed(s_tdata[2*DATA_W-1:DATA_W]);
                    if (s_tuser[0] == OP_CLEAR) begin
                        integral_next = '0;
                        sum_next      = '0;
                        count_next    = '0;
                        res_next      = '0;
                        state_next    = ST_DONE;
                    end else begin
                        state_next = ST_MUL_P;
                    end
                end
            end
            ST_MUL_P: begin
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                p_next     = p_clamped[DATA_W-1:0];
                state_next = ST_SUM;
            end
            ST_SUM: begin
                d_next = d_clamped[DATA_W-1:0];
                if (count_inc >= span_eff) begin
                    // window closed: divide the sum by the actual count
                    div_start  = 1'b1;
                    sum_next   = '0;
                    count_next = '0;
                    state_next = ST_DIV;
                end else begin
                    sum_next   = sum_inc;
                    count_next = count_inc;
                    state_next = ST_TOTAL;
                end
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    mean_next  = div_rsp.quotient;
                    state_next = ST_MUL_I;
                end
            end
            ST_MUL_I: begin
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                integral_next = integ_clamped[INTEG_W-1:0];
                state_next    = ST_TOTAL;
            end
            ST_TOTAL: begin
                res_next   = total_clamped[DATA_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            integral_reg <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            integral_reg <= integral_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
        end
        err_reg     <= err_next;
        slope_reg   <= slope_next;
        prod_reg    <= prod_next;
        p_reg       <= p_next;
        d_reg       <= d_next;
        mean_reg    <= mean_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign clear_beat  = s_acc && (s_tuser[0] == OP_CLEAR);
    assign integ_empty = (integral_reg == '0) && (sum_reg == '0) && (count_reg == '0);

    // A clear beat empties the integral path on the next edge
    `PIDDS_ASSERT_NEXT(a_clear_zeroes, aclk, aresetn, clear_beat, integ_empty)
    // The window count never reaches the maximum span between steps
    `PIDDS_ASSERT_NOW(a_count_below_max, aclk, aresetn, 1'b1, count_reg < SPAN_W'(MAX_SPAN))
    // Divider results arrive only while the sequencer waits for them
    `PIDDS_ASSERT_NOW(a_div_done_in_div, aclk, aresetn, div_rsp.done, state_reg == ST_DIV)

endmodule

### hw/rtl/pidds_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Depends on pidds_pkg.
module pidds_div
    import pidds_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [REM_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [SPAN_W-1:0]    dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;

    logic [REM_W-1:0]     shifted;
    logic                 fits;
    logic [DATA_W-1:0]    mag;

    assign shifted = {rem_reg[REM_W-2:0], quo_reg[SUM_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS - 1);
            rem_next  = '0;
            neg_next  = req.dividend[SUM_W-1];
            quo_next  = req.dividend[SUM_W-1] ? SUM_W'(-req.dividend) : SUM_W'(req.dividend);
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next = {quo_reg[SUM_W-2:0], fits};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // The mean of 16-bit samples always fits 16 bits.
    assign mag          = quo_reg[DATA_W-1:0];
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? $signed(-mag) : $signed(mag);

endmodule

### tb/pid_controller_downsampled_integral_tb.sv
// Self-checking bench for the PID controller with a downsampled integral term.
// Depends on pidds_pkg and the pid_controller_downsampled_integral RTL; reads no files.
// Predicts every drive beat in SystemVerilog and checks the result stream in order.
module pid_controller_downsampled_integral_tb
    import pidds_pkg::*;
();

    localparam int SETTLE_CYCLES = 48;    // covers the longest step, window close included, with slack
    localparam int STUCK_LIMIT   = 2000;  // cycles with work pending and no beat moving
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_BEATS   = 120;
    localparam int LONG_WINDOW   = 300;   // long run under a saturated span

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] err_sample;
        logic signed [DATA_W-1:0] err_slope;
    } pid_beat_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [31:0]        s_tdata   = '0;   // [15:0] err_sample, [31:16] err_slope
    logic [0:0]         s_tuser   = '0;   // [0] opcode
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [DATA_W-1:0]  m_tdata;          // [15:0] drive
    logic               cfg_we    = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [DATA_W-1:0]  cfg_wdata = '0;

    pid_beat_t                beats_to_send[$];
    logic signed [DATA_W-1:0] drive_expected[$];

    int  send_idle_pct = 27;
    int  recv_idle_pct = 51;
    int  mismatches    = 0;
    int  stuck_cycles  = 0;
    bit  in_taken      = 1'b0;  // input beat accepted at the last rising edge

    // Predictor copy of the registers and of the controller state.
    longint kp, ki, kd, p_lim, i_lim, d_lim, out_lim, avg_span;
    longint integ_acc, err_total, window_cnt;

    pid_controller_downsampled_integral i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    // Advance the controller state by one beat and return the drive it produces.
    function automatic logic signed [DATA_W-1:0] predict_drive(
        logic                     op,
        logic signed [DATA_W-1:0] err_in,
        logic signed [DATA_W-1:0] slope_in
    );
        longint err, slope, p_term, d_term, span, mean, total;
        if (op == OP_CLEAR) begin
            integ_acc  = 0;
            err_total  = 0;
            window_cnt = 0;
            return '0;
        end
        err    = err_in;
        slope  = slope_in;
        // SV division on signed longint truncates toward zero, as the block does
        p_term = clamp_to(err * kp / SCALE_ONE, p_lim);
        d_term = clamp_to(slope * kd / SCALE_ONE, d_lim);
        span   = avg_span;
        if (span < 1) begin
            span = 1;
        end
        if (span > MAX_SPAN) begin
            span = MAX_SPAN;
        end
        err_total  += err;
        window_cnt += 1;
        // Close the window on the actual count, so a lowered span fires at once
        if (window_cnt >= span) begin
            mean       = err_total / window_cnt;
            integ_acc  = clamp_to(integ_acc + mean * ki, i_lim * SCALE_ONE);
            window_cnt = 0;
            err_total  = 0;
        end
        total = clamp_to(p_term + d_term + integ_acc / SCALE_ONE, out_lim);
        return total[DATA_W-1:0];
    endfunction

    // Monitor: mirror register writes, predict on each input beat, check each result beat.
    always @(posedge aclk) begin : monitor
        logic signed [DATA_W-1:0] want;
        if (!aresetn) begin
            in_taken   = 1'b0;
            kp         = 0;
            ki         = 0;
            kd         = 0;
            p_lim      = 0;
            i_lim      = 0;
            d_lim      = 0;
            out_lim    = 0;
            avg_span   = SPAN_RESET;
            integ_acc  = 0;
            err_total  = 0;
            window_cnt = 0;
        end else begin
            in_taken = s_tvalid && s_tready;
            if (cfg_we) begin
                case (reg_idx_t'(cfg_index))
                    REG_PROP_GAIN:   kp       = longint'($signed(cfg_wdata));
                    REG_INTEG_GAIN:  ki       = longint'($signed(cfg_wdata));
                    REG_DERIV_GAIN:  kd       = longint'($signed(cfg_wdata));
                    REG_PROP_CLAMP:  p_lim    = longint'(cfg_wdata[LIM_W-1:0]);
                    REG_INTEG_CLAMP: i_lim    = longint'(cfg_wdata[LIM_W-1:0]);
                    REG_DERIV_CLAMP: d_lim    = longint'(cfg_wdata[LIM_W-1:0]);
                    REG_DRIVE_CLAMP: out_lim  = longint'(cfg_wdata[LIM_W-1:0]);
                    REG_AVG_SPAN:    avg_span = longint'(cfg_wdata[SPAN_W-1:0]);
                    default: ;
                endcase
            end
            if (in_taken) begin
                drive_expected.push_back(predict_drive(s_tuser[0], s_tdata[15:0],
                                                       s_tdata[31:16]));
            end
            if (m_tvalid && m_tready) begin
                if (drive_expected.size() == 0) begin
                    $display("%0t: unexpected drive beat, actual %0d", $time,
                             $signed(m_tdata));
                    mismatches++;
                end else begin
                    want = drive_expected.pop_front();
                    if (m_tdata !== want) begin
                        $display("%0t: drive mismatch, expected %0d, actual %0d", $time,
                                 want, $signed(m_tdata));
                        mismatches++;
                    end
                end
            end
        end
    end

    // Driver: present the next pending beat once the current one is taken,
    // holding tvalid low on a random share of cycles.
    always @(negedge aclk) begin : driver
        pid_beat_t b;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (beats_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                b = beats_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {b.err_slope, b.err_sample};
                s_tuser  <= b.opcode;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall the result stream on a random share of cycles.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: end the run if work is pending and no beat moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (beats_to_send.size() == 0 && !s_tvalid && drive_expected.size() == 0)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("pid_controller_downsampled_integral_tb: errors");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic push_beat(logic op, logic [DATA_W-1:0] err, logic [DATA_W-1:0] slope);
        pid_beat_t b;
        b.opcode     = op;
        b.err_sample = err;
        b.err_slope  = slope;
        beats_to_send.push_back(b);
    endtask

    // Only call while the block is idle.
    task automatic write_reg(reg_idx_t idx, int unsigned value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[DATA_W-1:0];
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Hold until every beat is sent and answered, then let the pipeline settle.
    task automatic wait_idle();
        while (beats_to_send.size() != 0 || s_tvalid || drive_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return 16'($urandom_range(512)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int unsigned rand_limit();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 32767;
            2:       return $urandom_range(63);
            default: return $urandom_range(32767);
        endcase
    endfunction

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset defaults: every clamp is zero, so each step must drive 0.
        push_beat(OP_STEP, 16'h7FFF, 16'h8000);
        push_beat(OP_STEP, 16'h8000, 16'h7FFF);
        push_beat(OP_CLEAR, 16'hFFFF, 16'hFFFF);
        wait_idle();

        // Extreme gains, wide clamps, zero span updates the integral every step.
        write_reg(REG_PROP_GAIN, 32'h7FFF);
        write_reg(REG_INTEG_GAIN, 32'h8000);
        write_reg(REG_DERIV_GAIN, 32'h8000);
        write_reg(REG_PROP_CLAMP, 32767);
        write_reg(REG_INTEG_CLAMP, 32767);
        write_reg(REG_DERIV_CLAMP, 32767);
        write_reg(REG_DRIVE_CLAMP, 32767);
        write_reg(REG_AVG_SPAN, 0);
        push_beat(OP_STEP, 16'h7FFF, 16'h7FFF);
        push_beat(OP_STEP, 16'h8000, 16'h8000);
        push_beat(OP_STEP, 16'hFFFF, 16'h0001);   // truncation toward zero, negative side
        push_beat(OP_STEP, 16'h0001, 16'hFFFF);
        push_beat(OP_STEP, 16'd255, -16'sd255);
        push_beat(OP_STEP, -16'sd257, 16'd257);
        push_beat(OP_CLEAR, 16'h8000, 16'h7FFF);
        push_beat(OP_STEP, 16'h0000, 16'h0000);
        wait_idle();

        // Tight clamps, zero integral and D limits, then lower the span mid-window.
        write_reg(REG_PROP_CLAMP, 1);
        write_reg(REG_DERIV_CLAMP, 0);
        write_reg(REG_INTEG_CLAMP, 0);
        write_reg(REG_DRIVE_CLAMP, 100);
        write_reg(REG_AVG_SPAN, 5);
        push_beat(OP_STEP, 16'd1000, 16'd1000);
        push_beat(OP_STEP, -16'sd1000, 16'd500);
        wait_idle();
        write_reg(REG_AVG_SPAN, 2);
        push_beat(OP_STEP, 16'd700, 16'd0);       // count reaches 3, past the new span
        push_beat(OP_STEP, 16'd3, 16'd3);
        wait_idle();
        write_reg(REG_INTEG_CLAMP, 10);
        write_reg(REG_DRIVE_CLAMP, 32767);
        write_reg(REG_AVG_SPAN, 3);
        repeat (3) push_beat(OP_STEP, 16'h8000, 16'h0000);
        wait_idle();

        // Random phases: fresh registers each time, mostly short averaging windows.
        // Windows carry across phases, so span changes also land mid-window.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph < RAND_PHASES / 3) begin
                send_idle_pct = 27;
                recv_idle_pct = 51;
            end else if (ph < 2 * RAND_PHASES / 3) begin
                send_idle_pct = 51;
                recv_idle_pct = 27;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_PROP_GAIN, rand_word());
            write_reg(REG_INTEG_GAIN, rand_word());
            write_reg(REG_DERIV_GAIN, rand_word());
            write_reg(REG_PROP_CLAMP, rand_limit());
            write_reg(REG_INTEG_CLAMP, rand_limit());
            write_reg(REG_DERIV_CLAMP, rand_limit());
            write_reg(REG_DRIVE_CLAMP, rand_limit());
            write_reg(REG_AVG_SPAN, (ph % 4 == 3) ? $urandom_range(8191, 17)
                                                  : $urandom_range(16, 0));
            for (int n = 0; n < PHASE_BEATS; n++) begin
                push_beat(($urandom_range(99) < 4) ? OP_CLEAR : OP_STEP,
                          rand_word(), rand_word());
            end
            wait_idle();
        end

        // Long run with a span above MAX_SPAN, which saturates; near-full-scale
        // errors build a large sum in the open window.
        write_reg(REG_INTEG_GAIN, 300);
        write_reg(REG_INTEG_CLAMP, 32767);
        write_reg(REG_DRIVE_CLAMP, 32767);
        write_reg(REG_AVG_SPAN, 8191);
        push_beat(OP_CLEAR, 16'h0000, 16'h0000);
        for (int n = 0; n < LONG_WINDOW; n++) begin
            push_beat(OP_STEP, ($urandom_range(7) == 0) ? rand_word() : 16'h8000,
                      rand_word());
        end
        wait_idle();

        if (mismatches == 0) begin
            $display("pid_controller_downsampled_integral_tb: clean");
        end else begin
            $display("pid_controller_downsampled_integral_tb: errors");
        end
        $finish;
    end

endmodule
